FILE: rtl/cbal_pkg.sv
`default_nettype none
package cbal_pkg;

	localparam int CW = 21;
	localparam logic [16:0] ONE_Q16 = 17'h10000;

	typedef enum logic [1:0] {
		REQ_BUILD = 2'd0,
		REQ_POS   = 2'd1,
		REQ_ARC   = 2'd2
	} req_t;

	typedef enum logic [11:0] {
		ST_IDLE  = 12'b000000000001,
		ST_LOAD  = 12'b000000000010,
		ST_EVAL  = 12'b000000000100,
		ST_BSQ   = 12'b000000001000,
		ST_BSQRT = 12'b000000010000,
		ST_BACC  = 12'b000000100000,
		ST_TGT   = 12'b000001000000,
		ST_SCAN  = 12'b000010000000,
		ST_MDEN  = 12'b000100000000,
		ST_MNUM  = 12'b001000000000,
		ST_DIV   = 12'b010000000000,
		ST_FIN   = 12'b100000000000
	} state_t;

endpackage
`default_nettype wire

FILE: rtl/cubic_bezier_arc_length_eval.sv
`default_nettype none
// channel   signals                             direction
// in        in_valid in_ready req_type param    item in
// out       out_valid out_ready pos_x pos_y     item out
//           pos_z total_len
// cfg       cfg_we cfg_idx cfg_data             register write
//
// Position request: curve evaluation on the shared lerp multiplier.
// Arc request: table scan over the memory port, 18-step divider, curve
// evaluation. Build request: evaluation, squares and a 22-step square
// root per sample. Reset is asynchronous; the table needs no clearing
// pass. in_ready is high only while idle; one finished item may wait in
// the output register while the next is taken.
module cubic_bezier_arc_length_eval #(
	parameter int SAMPLE_COUNT = 100
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [1:0]          req_type,
	input  wire logic [16:0]         param,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic signed [20:0]       pos_x,
	output logic signed [20:0]       pos_y,
	output logic signed [20:0]       pos_z,
	output logic [31:0]              total_len,
	input  wire logic                cfg_we,
	input  wire logic [1:0]          cfg_idx,
	input  wire logic [62:0]         cfg_data
);
	import cbal_pkg::*;

	localparam int IW    = $clog2(SAMPLE_COUNT + 1);
	localparam int RW    = $clog2(SAMPLE_COUNT) + 1;
	localparam int DENW  = 32 + IW;
	localparam int NW    = DENW + 18;
	localparam int QSTEP = 65536 / SAMPLE_COUNT;
	localparam int RSTEP = 65536 % SAMPLE_COUNT;
	localparam int HALF  = SAMPLE_COUNT / 2;
	localparam logic [IW-1:0] LAST_IDX = IW'(SAMPLE_COUNT);

	state_t state_q;
	logic [62:0] ctrl_q [4];
	logic [31:0] curve_len_q;
	logic out_valid_q;

	req_t mode_q;
	logic zlen_q;
	logic [4:0] cnt_q;
	logic [IW-1:0] i_q;
	logic [16:0] u_q;
	logic [RW-1:0] accr_q;
	logic [31:0] sum_q;
	logic signed [CW-1:0] q_q [12];
	logic signed [CW-1:0] prev_q [3];
	logic [43:0] sq_q, r_q, bit_q;
	logic [48:0] target_q;
	logic [IW-1:0] rd_i_q, k_q, cmp_idx_s1;
	logic cmp_v_s1, ff_q;
	logic [31:0] tk_q, tk1_q, tbl_rdata_q;
	logic [DENW-1:0] den_q;
	logic [NW-1:0] dr_q;
	logic signed [20:0] pos_x_q, pos_y_q, pos_z_q;
	logic [31:0] total_len_q;
	logic [31:0] tbl_mem [0:SAMPLE_COUNT];

	logic signed [33:0] mul_a;
	logic signed [22:0] mul_b;
	logic signed [56:0] mul_p;
	logic signed [21:0] ldiff, bdiff;
	logic signed [56:0] lsum;
	logic signed [CW-1:0] lerp_res;
	logic is_lerp, eval_last, fin_go, scan_done;
	logic [31:0] dval;
	logic [44:0] trial;
	logic [23:0] root;
	logic [32:0] ssum;
	logic [31:0] sat_sum;
	logic [RW-1:0] rs;
	logic r_wrap;
	logic [NW-1:0] num;
	logic [DENW:0] part;
	logic part_ge;
	logic [17:0] quo;
	logic [16:0] pclamp;
	logic tbl_we;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign pos_x     = pos_x_q;
	assign pos_y     = pos_y_q;
	assign pos_z     = pos_z_q;
	assign total_len = total_len_q;

	assign pclamp    = (param > ONE_Q16) ? ONE_Q16 : param;
	assign is_lerp   = (cnt_q < 5'd9) || (cnt_q >= 5'd12 && cnt_q < 5'd18) || (cnt_q >= 5'd24);
	assign eval_last = (cnt_q == 5'd26);
	assign fin_go    = !out_valid_q || out_ready;
	assign scan_done = cmp_v_s1 && (cmp_idx_s1 == LAST_IDX);
	assign dval      = tk1_q - tk_q;

	assign ldiff = {q_q[3][CW-1], q_q[3]} - {q_q[0][CW-1], q_q[0]};
	always_comb begin
		case (cnt_q[1:0])
			2'd0:    bdiff = {q_q[9][CW-1], q_q[9]} - {prev_q[0][CW-1], prev_q[0]};
			2'd1:    bdiff = {q_q[10][CW-1], q_q[10]} - {prev_q[1][CW-1], prev_q[1]};
			default: bdiff = {q_q[11][CW-1], q_q[11]} - {prev_q[2][CW-1], prev_q[2]};
		endcase
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_EVAL: begin
				mul_a = 34'(ldiff);
				mul_b = {6'd0, u_q};
			end
			ST_BSQ: begin
				mul_a = 34'(bdiff);
				mul_b = 23'(bdiff);
			end
			ST_TGT: begin
				mul_a = {2'd0, curve_len_q};
				mul_b = {6'd0, u_q};
			end
			ST_MDEN: begin
				mul_a = {2'd0, dval};
				mul_b = 23'(SAMPLE_COUNT);
			end
			ST_MNUM: begin
				mul_a = {2'd0, dval};
				mul_b = 23'(k_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	assign lsum     = mul_p + 57'sd32768;
	assign lerp_res = q_q[0] + lsum[36:16];

	assign trial   = {1'b0, r_q} + {1'b0, bit_q};
	assign root    = {1'b0, r_q[22:0]} + 24'(sq_q > r_q);
	assign ssum    = {1'b0, sum_q} + {9'd0, root};
	assign sat_sum = ssum[32] ? 32'hFFFFFFFF : ssum[31:0];

	assign rs     = accr_q + RW'(RSTEP);
	assign r_wrap = (rs >= RW'(SAMPLE_COUNT));

	assign num = (NW'(mul_p[IW+31:0]) << 16) + NW'(target_q) - (NW'(tk_q) << 16)
		+ NW'(den_q >> 1);
	assign part    = {dr_q[NW-1:18], dr_q[17]};
	assign part_ge = (part >= {1'b0, den_q});
	assign quo     = {dr_q[16:0], part_ge};

	assign tbl_we = (state_q == ST_BACC)
		|| (state_q == ST_EVAL && eval_last && mode_q == REQ_BUILD && i_q == '0);

	always_ff @(posedge clk) begin
		if (tbl_we) begin
			tbl_mem[i_q] <= (state_q == ST_BACC) ? sat_sum : 32'd0;
		end
		tbl_rdata_q <= tbl_mem[rd_i_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			curve_len_q <= '0;
			for (int p = 0; p < 4; p++) ctrl_q[p] <= '0;
		end else begin
			if (cfg_we) ctrl_q[cfg_idx] <= cfg_data;
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						case (req_type)
							REQ_BUILD, REQ_POS: state_q <= ST_LOAD;
							REQ_ARC: state_q <= (curve_len_q == '0) ? ST_FIN : ST_TGT;
							default: state_q <= ST_FIN;
						endcase
					end
				end
				ST_LOAD: state_q <= ST_EVAL;
				ST_EVAL: begin
					if (eval_last) begin
						if (mode_q != REQ_BUILD) state_q <= ST_FIN;
						else if (i_q == '0) state_q <= ST_LOAD;
						else state_q <= ST_BSQ;
					end
				end
				ST_BSQ: if (cnt_q == 5'd2) state_q <= ST_BSQRT;
				ST_BSQRT: if (bit_q[0]) state_q <= ST_BACC;
				ST_BACC: begin
					if (i_q == LAST_IDX) begin
						curve_len_q <= sat_sum;
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_LOAD;
					end
				end
				ST_TGT: state_q <= ST_SCAN;
				ST_SCAN: if (scan_done) state_q <= ST_MDEN;
				ST_MDEN: state_q <= (k_q == LAST_IDX) ? ST_LOAD : ST_MNUM;
				ST_MNUM: state_q <= ST_DIV;
				ST_DIV: if (cnt_q == 5'd17) state_q <= ST_LOAD;
				ST_FIN: begin
					if (fin_go) begin
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				mode_q <= req_t'(req_type);
				zlen_q <= (curve_len_q == '0);
				i_q    <= '0;
				u_q    <= (req_type == REQ_BUILD) ? 17'd0 : pclamp;
				accr_q <= RW'(HALF);
				sum_q  <= '0;
			end
			ST_LOAD: begin
				cnt_q <= '0;
				for (int p = 0; p < 4; p++)
					for (int c = 0; c < 3; c++)
						q_q[p*3+c] <= ctrl_q[p][c*CW +: CW];
			end
			ST_EVAL: begin
				cnt_q <= cnt_q + 5'd1;
				for (int e = 0; e < 11; e++) q_q[e] <= q_q[e+1];
				q_q[11] <= is_lerp ? lerp_res : q_q[0];
				if (eval_last && mode_q == REQ_BUILD) begin
					cnt_q <= '0;
					sq_q  <= '0;
					if (i_q == '0) begin
						prev_q[0] <= q_q[10];
						prev_q[1] <= q_q[11];
						prev_q[2] <= lerp_res;
						i_q    <= i_q + 1'b1;
						accr_q <= r_wrap ? rs - RW'(SAMPLE_COUNT) : rs;
						u_q    <= u_q + 17'(QSTEP) + 17'(r_wrap);
					end
				end
			end
			ST_BSQ: begin
				sq_q  <= sq_q + mul_p[43:0];
				cnt_q <= cnt_q + 5'd1;
				bit_q <= 44'd1 << 42;
				r_q   <= '0;
			end
			ST_BSQRT: begin
				if ({1'b0, sq_q} >= trial) begin
					sq_q <= sq_q - trial[43:0];
					r_q  <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			ST_BACC: begin
				sum_q     <= sat_sum;
				prev_q[0] <= q_q[9];
				prev_q[1] <= q_q[10];
				prev_q[2] <= q_q[11];
				i_q    <= i_q + 1'b1;
				accr_q <= r_wrap ? rs - RW'(SAMPLE_COUNT) : rs;
				u_q    <= u_q + 17'(QSTEP) + 17'(r_wrap);
			end
			ST_TGT: begin
				target_q <= mul_p[48:0];
				rd_i_q   <= IW'(1);
				cmp_v_s1 <= 1'b0;
				k_q      <= '0;
				tk_q     <= '0;
				ff_q     <= 1'b0;
			end
			ST_SCAN: begin
				cmp_idx_s1 <= rd_i_q;
				cmp_v_s1   <= 1'b1;
				if (rd_i_q != LAST_IDX) rd_i_q <= rd_i_q + 1'b1;
				if (cmp_v_s1) begin
					if ({1'b0, tbl_rdata_q} <= target_q[48:16]) begin
						k_q  <= cmp_idx_s1;
						tk_q <= tbl_rdata_q;
					end else if (!ff_q) begin
						ff_q  <= 1'b1;
						tk1_q <= tbl_rdata_q;
					end
				end
			end
			ST_MDEN: begin
				den_q <= mul_p[DENW-1:0];
				if (k_q == LAST_IDX) u_q <= ONE_Q16;
			end
			ST_MNUM: begin
				dr_q  <= num;
				cnt_q <= '0;
			end
			ST_DIV: begin
				cnt_q <= cnt_q + 5'd1;
				dr_q  <= {(part_ge ? part[DENW-1:0] - den_q : part[DENW-1:0]), dr_q[16:0], part_ge};
				if (cnt_q == 5'd17) u_q <= (quo > {1'b0, ONE_Q16}) ? ONE_Q16 : quo[16:0];
			end
			ST_FIN: begin
				if (fin_go) begin
					total_len_q <= curve_len_q;
					if (mode_q == REQ_POS || (mode_q == REQ_ARC && !zlen_q)) begin
						pos_x_q <= q_q[9];
						pos_y_q <= q_q[10];
						pos_z_q <= q_q[11];
					end else if (mode_q == REQ_ARC) begin
						pos_x_q <= ctrl_q[0][20:0];
						pos_y_q <= ctrl_q[0][41:21];
						pos_z_q <= ctrl_q[0][62:42];
					end else begin
						pos_x_q <= '0;
						pos_y_q <= '0;
						pos_z_q <= '0;
					end
				end
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

	a_eval_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EVAL) |-> (cnt_q <= 5'd26))
		else $error("eval step counter out of range");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (dr_q[NW-1:18] < den_q))
		else $error("divider remainder not below divisor");

	a_sqrt_bit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BSQRT) |-> (bit_q != '0))
		else $error("square root ran past its last step");

	a_fin_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && fin_go) |=> (out_valid_q && state_q == ST_IDLE))
		else $error("finished item not presented");

	a_scan_k: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MNUM) |-> (k_q < LAST_IDX && ff_q))
		else $error("segment search left no upper entry");

endmodule
`default_nettype wire
